/* design/hprb_pkg.sv */
// ----------------------------------------------------------------------------
// hprb_pkg
// Shared constants and controller/datapath interface types for the heap
// packet reorder buffer.
// ----------------------------------------------------------------------------
package hprb_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SEQ_BITS_DEF = 16;

  // Port widths fixed by the item format.
  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int GROUP_W  = 16;
  localparam int BSZ_W    = 7;

  // Longest run released at one block end, and the release buffer geometry.
  localparam int MAX_RUN = 64;
  localparam int RUN_CW  = $clog2(MAX_RUN + 1);
  localparam int RUN_AW  = $clog2(MAX_RUN);
  localparam int OUT_W   = SEQ_W + HANDLE_W;

  localparam logic [BSZ_W-1:0] BLOCK_SIZE_RST = 7'd8;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;

  typedef struct packed {
    logic accept;      // take the input item
    logic write_x;     // write the moving entry at the hole position
    logic rd_parent;   // read the parent of the hole
    logic move_up;     // move the parent down into the hole
    logic run_init;    // open a release check at a block end
    logic rd_root;     // read the heap root
    logic mark_drop;   // discard a stale root
    logic emit_store;  // buffer the root as a released packet
    logic pop_dec;     // shrink the heap, read its last entry
    logic load_x;      // last entry becomes the moving entry at the root
    logic rd_kids;     // read both children of the hole
    logic move_down;   // move the smaller child up into the hole
    logic emit_start;  // start streaming buffered results
    logic emit_rd;     // read one buffered result
    logic run_done;    // bump the group number
  } cmd_t;

  typedef struct packed {
    logic ins_pend;
    logic pos_zero;
    logic x_lt_par;
    logic blk_end;
    logic count_zero;
    logic count_one;
    logic n_full;
    logic n_zero;
    logic first_chk;
    logic root_eq;
    logic root_lt;
    logic lc_in;
    logic sd_move;
    logic idx_last;
  } status_t;

endpackage

/* design/hprb_ram.sv */
// ----------------------------------------------------------------------------
// hprb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hprb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/hprb_ctrl.sv */
// ----------------------------------------------------------------------------
// hprb_ctrl
// Sequencer for insert sift-up, release checks, pops with sift-down and
// streaming of the buffered release run.
// ----------------------------------------------------------------------------
module hprb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hprb_pkg::status_t st,
  output hprb_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_BLK_END,
    S_RD_ROOT,
    S_CHK_ROOT,
    S_POP,
    S_POP_LD,
    S_SD_RD,
    S_SD_CMP,
    S_FINISH,
    S_EMIT,
    S_EMIT_END
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (!st.ins_pend) begin
          state_next = S_BLK_END;
        end else if (st.pos_zero) begin
          cmd.write_x = 1'b1;
          state_next  = S_BLK_END;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (st.x_lt_par) begin
          cmd.move_up = 1'b1;
          state_next  = S_INS_CHK;
        end else begin
          cmd.write_x = 1'b1;
          state_next  = S_BLK_END;
        end
      end
      S_BLK_END: begin
        if (st.blk_end) begin
          cmd.run_init = 1'b1;
          state_next   = S_RD_ROOT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD_ROOT: begin
        if (st.n_full || st.count_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_root = 1'b1;
          state_next  = S_CHK_ROOT;
        end
      end
      S_CHK_ROOT: begin
        priority if (st.first_chk && !st.root_eq) begin
          state_next = S_IDLE;
        end else if (st.root_lt) begin
          cmd.mark_drop = 1'b1;
          state_next    = S_POP;
        end else if (st.root_eq) begin
          cmd.emit_store = 1'b1;
          state_next     = S_POP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_POP: begin
        cmd.pop_dec = 1'b1;
        state_next  = st.count_one ? S_RD_ROOT : S_POP_LD;
      end
      S_POP_LD: begin
        cmd.load_x = 1'b1;
        state_next = S_SD_RD;
      end
      S_SD_RD: begin
        if (st.lc_in) begin
          cmd.rd_kids = 1'b1;
          state_next  = S_SD_CMP;
        end else begin
          cmd.write_x = 1'b1;
          state_next  = S_RD_ROOT;
        end
      end
      S_SD_CMP: begin
        if (st.sd_move) begin
          cmd.move_down = 1'b1;
          state_next    = S_SD_RD;
        end else begin
          cmd.write_x = 1'b1;
          state_next  = S_RD_ROOT;
        end
      end
      S_FINISH: begin
        if (st.n_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_rd = 1'b1;
        if (st.idx_last) begin
          state_next = S_EMIT_END;
        end
      end
      S_EMIT_END: begin
        cmd.run_done = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/hprb_dp.sv */
// ----------------------------------------------------------------------------
// hprb_dp
// Datapath: heap storage (two mirrored RAMs for two read ports), the hole
// register for sifting, sequence and block bookkeeping, the release buffer
// and the configuration register.
// ----------------------------------------------------------------------------
module hprb_dp #(
  parameter int CAPACITY = hprb_pkg::CAPACITY_DEF,
  parameter int SEQ_BITS = hprb_pkg::SEQ_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hprb_pkg::cmd_t                     cmd,
  output hprb_pkg::status_t                  st,
  input  logic [hprb_pkg::SEQ_W-1:0]         seq_num,
  input  logic [hprb_pkg::HANDLE_W-1:0]      payload_handle,
  input  logic                               final_packet,
  output logic                               out_valid,
  output logic [hprb_pkg::SEQ_W-1:0]         out_seq,
  output logic [hprb_pkg::HANDLE_W-1:0]      out_handle,
  output logic [hprb_pkg::GROUP_W-1:0]       group_index,
  output logic                               last_of_run,
  output logic                               overflow,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hprb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hprb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hprb_pkg::APB_DATA_W-1:0]    prdata
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int LW    = AW + 2;
  localparam int HW    = hprb_pkg::HANDLE_W;
  localparam int ENT_W = SEQ_BITS + HW;

  // Bookkeeping registers.
  logic [CW-1:0]                 heap_count;
  logic [SEQ_BITS-1:0]           expected_seq;
  logic [hprb_pkg::BSZ_W-1:0]    block_fill;
  logic [hprb_pkg::GROUP_W-1:0]  run_counter;
  logic                          dropped_flag;
  logic [hprb_pkg::BSZ_W-1:0]    block_size;
  logic                          ins_pend;
  logic                          blk_end;
  logic                          first_chk;
  logic [hprb_pkg::RUN_CW-1:0]   run_n;
  logic [hprb_pkg::RUN_AW-1:0]   emit_idx;

  // Hole position and the entry that travels through the heap.
  logic [AW-1:0]    pos;
  logic [ENT_W-1:0] x_ent;

  // Heap RAM ports.
  logic             heap_we;
  logic [AW-1:0]    heap_waddr;
  logic [ENT_W-1:0] heap_wdata;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [ENT_W-1:0] rd_a;
  logic [ENT_W-1:0] rd_b;

  // Release buffer ports.
  logic [hprb_pkg::OUT_W-1:0] ob_wdata;
  logic [hprb_pkg::OUT_W-1:0] ob_rdata;

  logic [SEQ_BITS-1:0]        in_key;
  logic                       in_drop;
  logic [hprb_pkg::BSZ_W-1:0] bsize;
  logic [hprb_pkg::BSZ_W-1:0] fill_inc;
  logic                       in_end;
  logic [AW-1:0]              parent;
  logic [LW-1:0]              lc;
  logic [LW-1:0]              rc;
  logic                       rc_in;
  logic                       lc_lt;
  logic [SEQ_BITS-1:0]        best_key;
  logic                       rc_best;
  logic [ENT_W-1:0]           best_ent;
  logic [SEQ_BITS-1:0]        x_key;
  logic [SEQ_BITS-1:0]        a_key;
  logic [SEQ_BITS-1:0]        b_key;
  logic                       cfg_we;

  assign in_key  = SEQ_BITS'(seq_num);
  assign in_drop = (in_key < expected_seq) || (heap_count == CW'(CAPACITY));
  assign bsize   = (block_size == '0) ? hprb_pkg::BSZ_W'(1) : block_size;
  assign fill_inc = block_fill + hprb_pkg::BSZ_W'(1);
  assign in_end  = final_packet || (fill_inc >= bsize);

  assign x_key = x_ent[ENT_W-1:HW];
  assign a_key = rd_a[ENT_W-1:HW];
  assign b_key = rd_b[ENT_W-1:HW];

  assign parent = (pos - AW'(1)) >> 1;
  assign lc     = {1'b0, pos, 1'b1};
  assign rc     = LW'({pos, 1'b1}) + LW'(1);
  assign rc_in  = rc < LW'(heap_count);

  // Smaller of the hole entry and its children; ties keep the upper entry.
  assign lc_lt    = a_key < x_key;
  assign best_key = lc_lt ? a_key : x_key;
  assign rc_best  = rc_in && (b_key < best_key);
  assign best_ent = rc_best ? rd_b : rd_a;

  assign heap_we    = cmd.write_x || cmd.move_up || cmd.move_down;
  assign heap_waddr = pos;

  always_comb begin
    priority if (cmd.write_x) begin
      heap_wdata = x_ent;
    end else if (cmd.move_up) begin
      heap_wdata = rd_a;
    end else begin
      heap_wdata = best_ent;
    end
  end

  always_comb begin
    priority if (cmd.rd_parent) begin
      raddr_a = parent;
    end else if (cmd.pop_dec) begin
      raddr_a = AW'(heap_count - CW'(1));
    end else if (cmd.rd_kids) begin
      raddr_a = lc[AW-1:0];
    end else begin
      raddr_a = '0;
    end
  end

  assign raddr_b = rc[AW-1:0];

  hprb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_heap_a (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  hprb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_heap_b (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  assign ob_wdata = {hprb_pkg::SEQ_W'(a_key), rd_a[HW-1:0]};

  hprb_ram #(
    .WIDTH (hprb_pkg::OUT_W),
    .DEPTH (hprb_pkg::MAX_RUN)
  ) u_release_buf (
    .clk   (clk),
    .we    (cmd.emit_store),
    .waddr (run_n[hprb_pkg::RUN_AW-1:0]),
    .wdata (ob_wdata),
    .raddr (emit_idx),
    .rdata (ob_rdata)
  );

  // Configuration register.
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[hprb_pkg::APB_ADDR_W-1:2] == hprb_pkg::REG_BLOCK_SIZE);
  assign prdata = (paddr[hprb_pkg::APB_ADDR_W-1:2] == hprb_pkg::REG_BLOCK_SIZE) ?
                  hprb_pkg::APB_DATA_W'(block_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count   <= '0;
      expected_seq <= '0;
      block_fill   <= '0;
      run_counter  <= '0;
      dropped_flag <= 1'b0;
      block_size   <= hprb_pkg::BLOCK_SIZE_RST;
      ins_pend     <= 1'b0;
      blk_end      <= 1'b0;
      first_chk    <= 1'b0;
      run_n        <= '0;
      emit_idx     <= '0;
      out_valid    <= 1'b0;
      last_of_run  <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_size <= pwdata[hprb_pkg::BSZ_W-1:0];
      end
      if (cmd.accept) begin
        ins_pend   <= !in_drop;
        blk_end    <= in_end;
        block_fill <= in_end ? '0 : fill_inc;
        if (in_drop) begin
          dropped_flag <= 1'b1;
        end else begin
          heap_count <= heap_count + CW'(1);
        end
      end
      if (cmd.run_init) begin
        first_chk <= 1'b1;
        run_n     <= '0;
      end
      if (cmd.mark_drop) begin
        dropped_flag <= 1'b1;
      end
      if (cmd.emit_store) begin
        first_chk    <= 1'b0;
        run_n        <= run_n + hprb_pkg::RUN_CW'(1);
        expected_seq <= expected_seq + SEQ_BITS'(1);
      end
      if (cmd.pop_dec) begin
        heap_count <= heap_count - CW'(1);
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_rd) begin
        emit_idx <= emit_idx + hprb_pkg::RUN_AW'(1);
      end
      out_valid <= cmd.emit_rd;
      if (cmd.emit_rd) begin
        last_of_run <= st.idx_last;
      end
      if (cmd.run_done) begin
        run_counter <= run_counter + hprb_pkg::GROUP_W'(1);
      end
    end
  end

  // The hole position and the moving entry (key and handle) have no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos   <= heap_count[AW-1:0];
      x_ent <= {in_key, payload_handle};
    end else if (cmd.move_up) begin
      pos <= parent;
    end else if (cmd.load_x) begin
      pos   <= '0;
      x_ent <= rd_a;
    end else if (cmd.move_down) begin
      pos <= rc_best ? rc[AW-1:0] : lc[AW-1:0];
    end
  end

  assign out_seq     = ob_rdata[hprb_pkg::OUT_W-1:HW];
  assign out_handle  = ob_rdata[HW-1:0];
  assign group_index = run_counter;
  assign overflow    = dropped_flag;

  always_comb begin
    st            = '0;
    st.ins_pend   = ins_pend;
    st.pos_zero   = (pos == '0);
    st.x_lt_par   = x_key < a_key;
    st.blk_end    = blk_end;
    st.count_zero = (heap_count == '0);
    st.count_one  = (heap_count == CW'(1));
    st.n_full     = (run_n == hprb_pkg::RUN_CW'(hprb_pkg::MAX_RUN));
    st.n_zero     = (run_n == '0);
    st.first_chk  = first_chk;
    st.root_eq    = (a_key == expected_seq);
    st.root_lt    = (a_key < expected_seq);
    st.lc_in      = lc < LW'(heap_count);
    st.sd_move    = lc_lt || rc_best;
    st.idx_last   = (hprb_pkg::RUN_CW'(emit_idx) + hprb_pkg::RUN_CW'(1)) == run_n;
  end

endmodule

/* design/heap_packet_reorder_buffer_core.sv */
// ----------------------------------------------------------------------------
// heap_packet_reorder_buffer_core
// Reorder buffer on a binary min-heap keyed by packet sequence number.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until all work for that item, including any released packets, is done.
// A dropped packet or one that lands in an empty heap needs no sift-up; a new
// entry climbs toward the root, and each level costs a parent read and a
// compare-and-write. A block end adds a final root check. Each released or
// discarded root is popped, and unless it was the last entry in the heap, the
// last entry then sifts down from the root, each level costing a read of both
// children and a compare-and-write. Released packets are collected in a
// 64-entry buffer and driven out on consecutive cycles, each on the result
// ports for a single cycle marked by out_valid; busy stays high while the last
// one is on the ports. The receiver cannot stall the results, so it must take
// every transfer in the cycle it appears. The overflow flag given with each
// result is the sticky drop flag as it stands after the whole run. There is no
// clearing pass after reset.
module heap_packet_reorder_buffer_core #(
  parameter int CAPACITY = hprb_pkg::CAPACITY_DEF,
  parameter int SEQ_BITS = hprb_pkg::SEQ_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [hprb_pkg::SEQ_W-1:0]         seq_num,
  input  logic [hprb_pkg::HANDLE_W-1:0]      payload_handle,
  input  logic                               final_packet,
  output logic                               out_valid,
  output logic [hprb_pkg::SEQ_W-1:0]         out_seq,
  output logic [hprb_pkg::HANDLE_W-1:0]      out_handle,
  output logic [hprb_pkg::GROUP_W-1:0]       group_index,
  output logic                               last_of_run,
  output logic                               overflow,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hprb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hprb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hprb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  hprb_pkg::cmd_t    cmd;
  hprb_pkg::status_t st;

  assign pready = 1'b1;

  hprb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  hprb_dp #(
    .CAPACITY (CAPACITY),
    .SEQ_BITS (SEQ_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .seq_num        (seq_num),
    .payload_handle (payload_handle),
    .final_packet   (final_packet),
    .out_valid      (out_valid),
    .out_seq        (out_seq),
    .out_handle     (out_handle),
    .group_index    (group_index),
    .last_of_run    (last_of_run),
    .overflow       (overflow),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

endmodule

/* sim/tb_heap_packet_reorder_buffer_core.sv */
// ----------------------------------------------------------------------------
// tb_heap_packet_reorder_buffer_core
// Self-checking testbench for the heap packet reorder buffer. A behavioral
// min-heap model predicts every released packet. Directed tests cover
// in-order and shuffled blocks, stale and duplicate packets, zero block size,
// a full heap with a 64-packet run and field extremes. Random phases then
// send shuffled windows of consecutive sequence numbers mixed with noise,
// over several block sizes and with random gaps on the command side.
// ----------------------------------------------------------------------------
module tb_heap_packet_reorder_buffer_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_W      = hprb_pkg::SEQ_W;
  localparam int HANDLE_W   = hprb_pkg::HANDLE_W;
  localparam int GROUP_W    = hprb_pkg::GROUP_W;
  localparam int BSZ_W      = hprb_pkg::BSZ_W;
  localparam int APB_ADDR_W = hprb_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = hprb_pkg::APB_DATA_W;
  localparam int MAX_RUN    = hprb_pkg::MAX_RUN;
  localparam int HEAP_DEPTH = hprb_pkg::CAPACITY_DEF;
  localparam logic [hprb_pkg::REG_IDX_W-1:0] REG_BLOCK_SIZE = hprb_pkg::REG_BLOCK_SIZE;
  localparam logic [BSZ_W-1:0] BLOCK_SIZE_RST = hprb_pkg::BLOCK_SIZE_RST;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [GROUP_W-1:0]  group;
    logic                last;
    logic                ovf;
  } pkt_out_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [SEQ_W-1:0]      seq_num;
  logic [HANDLE_W-1:0]   payload_handle;
  logic                  final_packet;
  logic                  out_valid;
  logic [SEQ_W-1:0]      out_seq;
  logic [HANDLE_W-1:0]   out_handle;
  logic [GROUP_W-1:0]    group_index;
  logic                  last_of_run;
  logic                  overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  heap_packet_reorder_buffer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seq_num(seq_num), .payload_handle(payload_handle), .final_packet(final_packet),
    .out_valid(out_valid), .out_seq(out_seq), .out_handle(out_handle),
    .group_index(group_index), .last_of_run(last_of_run), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Model state of the reorder buffer.
  slot_t            heap_mem [HEAP_DEPTH];
  int unsigned      heap_cnt;
  logic [SEQ_W-1:0] next_seq;
  logic [BSZ_W-1:0] fill_cnt;
  logic [GROUP_W-1:0] group_cnt;
  logic             drop_seen;
  logic [BSZ_W-1:0] block_size_reg;

  pkt_out_t release_q[$];
  int err_count;
  int pkts_sent;
  int issue_next;
  bit idle_on;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    slot_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void heap_push(input logic [SEQ_W-1:0] s, input logic [HANDLE_W-1:0] h);
    int pos;
    int up;
    pos = heap_cnt;
    heap_mem[pos] = '{seq: s, handle: h};
    heap_cnt++;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_mem[pos].seq < heap_mem[up].seq) begin
        swap_slots(pos, up);
        pos = up;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void heap_pop();
    int pos;
    int best;
    int lc;
    int rc;
    if (heap_cnt == 0) return;
    heap_cnt--;
    heap_mem[0] = heap_mem[heap_cnt];
    pos = 0;
    while (pos < heap_cnt) begin
      best = pos;
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      if (lc < heap_cnt && heap_mem[lc].seq < heap_mem[best].seq) best = lc;
      if (rc < heap_cnt && heap_mem[rc].seq < heap_mem[best].seq) best = rc;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic bit heap_holds(input logic [SEQ_W-1:0] s);
    for (int i = 0; i < heap_cnt; i++)
      if (heap_mem[i].seq == s) return 1'b1;
    return 1'b0;
  endfunction

  // Insert one packet and, at a block end, release the consecutive run.
  function automatic void predict_release(input logic [SEQ_W-1:0] s,
                                          input logic [HANDLE_W-1:0] h,
                                          input logic fin);
    logic [BSZ_W-1:0] bsz;
    pkt_out_t run_pkts[$];
    pkt_out_t p;
    bsz = (block_size_reg == '0) ? BSZ_W'(1) : block_size_reg;
    if (s < next_seq || heap_cnt >= HEAP_DEPTH) drop_seen = 1'b1;
    else heap_push(s, h);
    fill_cnt = fill_cnt + 1'b1;
    if (!(fin || fill_cnt >= bsz)) return;
    fill_cnt = '0;
    if (heap_cnt == 0 || heap_mem[0].seq != next_seq) return;
    while (run_pkts.size() < MAX_RUN && heap_cnt > 0) begin
      // A copy of a number already released is discarded.
      while (heap_cnt > 0 && heap_mem[0].seq < next_seq) begin
        drop_seen = 1'b1;
        heap_pop();
      end
      if (heap_cnt == 0 || heap_mem[0].seq != next_seq) break;
      p = '{seq: heap_mem[0].seq, handle: heap_mem[0].handle, group: group_cnt,
            last: 1'b0, ovf: 1'b0};
      run_pkts.push_back(p);
      heap_pop();
      next_seq = next_seq + 1'b1;
    end
    foreach (run_pkts[i]) begin
      p = run_pkts[i];
      p.ovf = drop_seen;
      p.last = (i == run_pkts.size() - 1);
      release_q.push_back(p);
    end
    if (run_pkts.size() > 0) group_cnt = group_cnt + 1'b1;
  endfunction

  // Every strobed result is compared with the oldest prediction.
  always @(posedge clk) begin
    pkt_out_t want;
    if (!rst && out_valid) begin
      if (release_q.size() == 0) begin
        report_mismatch("result with no prediction pending, out_seq", int'(out_seq), 0);
      end else begin
        want = release_q.pop_front();
        if (out_seq !== want.seq)
          report_mismatch("out_seq", int'(out_seq), int'(want.seq));
        if (out_handle !== want.handle)
          report_mismatch("out_handle", int'(out_handle), int'(want.handle));
        if (group_index !== want.group)
          report_mismatch("group_index", int'(group_index), int'(want.group));
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
        if (overflow !== want.ovf)
          report_mismatch("overflow", int'(overflow), int'(want.ovf));
      end
    end
  end

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One command transfer: held until the block takes it.
  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic [HANDLE_W-1:0] h,
                             input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
    seq_num        <= s;
    payload_handle <= h;
    final_packet   <= fin;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_release(s, h, fin);
    pkts_sent++;
  endtask

  // Wait until every prediction has been matched and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [BSZ_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_SIZE, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    block_size_reg = val;
    @(posedge clk);
  endtask

  task automatic reg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_BLOCK_SIZE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[BSZ_W-1:0] !== block_size_reg)
      report_mismatch("block_size readback", int'(prdata), int'(block_size_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_block_size(input logic [BSZ_W-1:0] val);
    wait_idle();
    reg_write(val);
    reg_check();
  endtask

  function automatic logic [HANDLE_W-1:0] rand_handle();
    return HANDLE_W'($urandom);
  endfunction

  task automatic test_register_access();
    reg_check();
    reg_write(7'd5);
    reg_check();
    reg_write(BLOCK_SIZE_RST);
    reg_check();
  endtask

  task automatic test_in_order();
    logic [SEQ_W-1:0] b;
    b = next_seq;
    for (int i = 0; i < 4; i++) send_packet(SEQ_W'(b + i), rand_handle(), i == 3);
    set_block_size(7'd3);
    // A block that ends by its count, not by a final packet.
    for (int i = 4; i < 7; i++) send_packet(SEQ_W'(b + i), rand_handle(), 1'b0);
  endtask

  task automatic test_out_of_order();
    logic [SEQ_W-1:0] b;
    set_block_size(BLOCK_SIZE_RST);
    b = next_seq;
    send_packet(b + SEQ_W'(2), rand_handle(), 1'b0);
    send_packet(b + SEQ_W'(1), rand_handle(), 1'b0);
    send_packet(b + SEQ_W'(3), rand_handle(), 1'b0);
    send_packet(b, rand_handle(), 1'b1);
    // A block end whose minimum is ahead of the expected number releases nothing.
    send_packet(b + SEQ_W'(5), rand_handle(), 1'b1);
    send_packet(b + SEQ_W'(4), rand_handle(), 1'b1);
  endtask

  task automatic test_stale_and_duplicate();
    logic [SEQ_W-1:0] b;
    b = next_seq;
    send_packet('0, rand_handle(), 1'b1);
    send_packet(b + SEQ_W'(1), rand_handle(), 1'b0);
    send_packet(b + SEQ_W'(1), rand_handle(), 1'b0);
    send_packet(b, rand_handle(), 1'b1);
  endtask

  task automatic test_zero_block_size();
    logic [SEQ_W-1:0] b;
    set_block_size('0);
    b = next_seq;
    send_packet(b + SEQ_W'(1), rand_handle(), 1'b0);
    send_packet(b, rand_handle(), 1'b0);
  endtask

  // Fill the heap, overrun it, then release all 64 entries in one run.
  task automatic test_full_heap_long_run();
    logic [SEQ_W-1:0] b;
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] t;
    int j;
    set_block_size(7'd127);
    b = next_seq;
    for (int i = 0; i < HEAP_DEPTH; i++) order.push_back(SEQ_W'(b + i));
    for (int i = HEAP_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_packet(order[i], rand_handle(), 1'b0);
    send_packet(SEQ_W'(b + HEAP_DEPTH), rand_handle(), 1'b0);
    send_packet(SEQ_W'(b + HEAP_DEPTH + 1), rand_handle(), 1'b1);
    wait_idle();
    issue_next = int'(next_seq);
  endtask

  task automatic test_field_extremes();
    logic [SEQ_W-1:0] b;
    set_block_size(7'd64);
    b = next_seq;
    send_packet(b, 16'h0000, 1'b0);
    send_packet(b + SEQ_W'(1), 16'hFFFF, 1'b0);
    send_packet(b + SEQ_W'(2), 16'hAAAA, 1'b0);
    send_packet(b + SEQ_W'(3), 16'h5555, 1'b1);
    // Far-future numbers stay parked in the heap for the rest of the run.
    send_packet(16'hFFFF, rand_handle(), 1'b0);
    send_packet(16'h8000, rand_handle(), 1'b1);
    issue_next = int'(next_seq);
  endtask

  // A shuffled window of consecutive numbers, with some stale, duplicate
  // and far-future noise mixed in.
  task automatic send_window(input int len, input int fin_div);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] t;
    int j;
    int lo;
    // A number lost to a full heap would stall every release; send it again.
    if (next_seq < issue_next && !heap_holds(next_seq))
      send_packet(next_seq, rand_handle(), 1'b0);
    for (int i = 0; i < len; i++) order.push_back(SEQ_W'(issue_next + i));
    issue_next += len;
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      case ($urandom_range(0, 39))
        0, 1: if (next_seq > 0)
                send_packet(SEQ_W'($urandom_range(0, next_seq - 1)), rand_handle(),
                            1'($urandom_range(0, 1)));
        2, 3: begin
          lo = (issue_next > 24) ? issue_next - 24 : 0;
          send_packet(SEQ_W'($urandom_range(lo, issue_next - 1)), rand_handle(), 1'b0);
        end
        4: if ($urandom_range(0, 7) == 0)
             send_packet(SEQ_W'($urandom_range(1024, 65535)), rand_handle(), 1'b0);
        default: ;
      endcase
      send_packet(order[i], rand_handle(), $urandom_range(1, fin_div) == 1);
    end
  endtask

  task automatic run_random_phase(input logic [BSZ_W-1:0] bsz, input int n_pkts,
                                  input int fin_div);
    int stop_at;
    set_block_size(bsz);
    stop_at = pkts_sent + n_pkts;
    while (pkts_sent < stop_at) send_window($urandom_range(1, 12), fin_div);
  endtask

  task automatic test_random_traffic();
    run_random_phase(7'd1, 20, 8);
    run_random_phase(7'd4, 20, 8);
    run_random_phase(7'd13, 20, 8);
    run_random_phase(7'd64, 20, 5);
    run_random_phase(7'd2, 20, 8);
    run_random_phase(7'd127, 20, 4);
    run_random_phase(7'd8, 20, 8);
    run_random_phase(7'd5, 20, 8);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_random_phase(7'd16, 40, 8);
  endtask

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    seq_num        <= '0;
    payload_handle <= '0;
    final_packet   <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    heap_cnt       = 0;
    next_seq       = '0;
    fill_cnt       = '0;
    group_cnt      = '0;
    drop_seen      = 1'b0;
    block_size_reg = BLOCK_SIZE_RST;
    err_count      = 0;
    pkts_sent      = 0;
    issue_next     = 0;
    idle_on        = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_in_order();
    test_out_of_order();
    test_stale_and_duplicate();
    test_zero_block_size();
    test_full_heap_long_run();
    test_field_extremes();
    test_random_traffic();
    test_back_to_back();

    start <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("ERROR: timeout with %0d results still pending", release_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
